FILE: rtl/sars_pkg.sv
package sars_pkg;

  localparam int unsigned FIELD_W = 31;

  typedef struct packed {
    logic [FIELD_W-1:0] hash_value;
    logic [FIELD_W-1:0] priv_exponent;
    logic [FIELD_W-1:0] modulus;
    logic               last_signer;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] signature;
    logic               is_final;
    logic               order_error;
  } out_item_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_RED,
    OP_MUL_BASE,
    OP_MUL_ACC,
    OP_MUL_SQR,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_start;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_bit;
    logic exp_zero;
    logic small_mod;
  } dp_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_BASE,
    ST_CHECK,
    ST_ACC,
    ST_SQR,
    ST_DONE
  } ctrl_state_t;

endpackage

FILE: rtl/sars_modmul.sv
// serial modular multiplier: r = a*b mod n, one multiplier bit per cycle
module sars_modmul #(
  parameter int unsigned W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] n,
  output logic         done,
  output logic [W-1:0] r
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W+1:0]  dbl, sum;

  // double and add, reducing after each with a single subtract
  always_comb begin
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dbl = {1'b0, acc_r, 1'b0};
    if (dbl >= {2'b00, n}) dbl = dbl - {2'b00, n};
    sum = dbl + (b_r[W-1] ? {2'b00, a} : '0);
    if (sum >= {2'b00, n}) sum = sum - {2'b00, n};
    if (start) begin
      acc_nxt  = '0;
      b_nxt    = b;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum[W-1:0];
      b_nxt   = {b_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign r    = acc_r;
endmodule

FILE: rtl/sars_datapath.sv
// operand registers, chain state and the shared modular multiplier
module sars_datapath #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sars_pkg::in_item_t  in_item,
  input  sars_pkg::dp_cmd_t   cmd,
  output sars_pkg::dp_sts_t   sts,
  output sars_pkg::out_item_t res
);
  import sars_pkg::*;

  logic [MOD_BITS-1:0] h_r, h_nxt, d_r, d_nxt, n_r, n_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt, b_r, b_nxt;
  logic [MOD_BITS-1:0] sig_r, sig_nxt, prev_r, prev_nxt;
  logic                bad_r, bad_nxt, last_r, last_nxt;
  out_item_t           res_r, res_nxt;
  logic [MOD_BITS-1:0] ma, mb, mr, in_n;
  logic                mdone;

  assign in_n = in_item.modulus[MOD_BITS-1:0];

  // multiplier operand selection
  always_comb begin
    case (cmd.op)
      OP_MUL_RED:  begin ma = MOD_BITS'(1); mb = sig_r; end
      OP_MUL_BASE: begin ma = b_r;   mb = h_r; end
      OP_MUL_ACC:  begin ma = acc_r; mb = b_r; end
      OP_MUL_SQR:  begin ma = b_r;   mb = b_r; end
      default:     begin ma = b_r;   mb = b_r; end
    endcase
  end

  sars_modmul #(.W(MOD_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.mul_start),
    .a(ma), .b(mb), .n(n_r), .done(mdone), .r(mr)
  );

  // state updates per operation
  always_comb begin
    h_nxt = h_r; d_nxt = d_r; n_nxt = n_r; acc_nxt = acc_r; b_nxt = b_r;
    sig_nxt = sig_r; prev_nxt = prev_r; bad_nxt = bad_r; last_nxt = last_r;
    res_nxt = res_r;
    case (cmd.op)
      OP_LOAD: begin
        // running signature is reduced by a multiply with one, the hash by the base multiply
        h_nxt    = in_item.hash_value[MOD_BITS-1:0];
        d_nxt    = in_item.priv_exponent[MOD_BITS-1:0];
        n_nxt    = in_n;
        last_nxt = in_item.last_signer;
        prev_nxt = in_n;
        if (in_n < prev_r) bad_nxt = 1'b1;
        acc_nxt  = MOD_BITS'(1);
      end
      OP_MUL_RED:  if (mdone) b_nxt = mr;
      OP_MUL_BASE: if (mdone) b_nxt = mr;
      OP_MUL_ACC:  if (mdone) acc_nxt = mr;
      OP_MUL_SQR:  if (mdone) begin
        b_nxt = mr;
        d_nxt = d_r >> 1;
      end
      OP_FINISH: begin
        res_nxt.signature   = (n_r < MOD_BITS'(2)) ? '0 : FIELD_W'(acc_r);
        res_nxt.is_final    = last_r;
        res_nxt.order_error = bad_r;
        sig_nxt = (n_r < MOD_BITS'(2)) ? '0 : acc_r;
        if (last_r) begin
          sig_nxt  = MOD_BITS'(1);
          prev_nxt = '0;
          bad_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r  <= MOD_BITS'(1);
      prev_r <= '0;
      bad_r  <= 1'b0;
    end else begin
      sig_r  <= sig_nxt;
      prev_r <= prev_nxt;
      bad_r  <= bad_nxt;
    end
    h_r <= h_nxt; d_r <= d_nxt; n_r <= n_nxt; acc_r <= acc_nxt; b_r <= b_nxt;
    last_r <= last_nxt; res_r <= res_nxt;
  end

  assign sts.mul_done  = mdone;
  assign sts.exp_bit   = d_r[0];
  assign sts.exp_zero  = (d_r == '0);
  assign sts.small_mod = (n_r < MOD_BITS'(2));
  assign res = res_r;
endmodule

FILE: rtl/sars_ctrl.sv
// sequencer for reduction, base multiply and square-and-multiply
module sars_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sars_pkg::dp_sts_t sts,
  output sars_pkg::dp_cmd_t cmd
);
  import sars_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        ov_r, ov_nxt;
  logic        started_r, started_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid && (!ov_r || out_ready)) state_nxt = ST_RED;
      ST_RED:   if (sts.small_mod) state_nxt = ST_DONE;
                else if (started_r && sts.mul_done) state_nxt = ST_BASE;
      ST_BASE:  if (started_r && sts.mul_done) state_nxt = ST_CHECK;
      ST_CHECK: if (sts.exp_zero) state_nxt = ST_DONE;
                else if (sts.exp_bit) state_nxt = ST_ACC;
                else state_nxt = ST_SQR;
      ST_ACC:   if (started_r && sts.mul_done) state_nxt = ST_SQR;
      ST_SQR:   if (started_r && sts.mul_done) state_nxt = ST_CHECK;
      ST_DONE:  if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op = OP_NONE;
    cmd.mul_start = 1'b0;
    started_nxt = started_r;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !ov_r || out_ready;
        if (in_valid && in_ready) cmd.op = OP_LOAD;
        started_nxt = 1'b0;
      end
      ST_RED, ST_BASE, ST_ACC, ST_SQR: begin
        cmd.op = (state_r == ST_RED) ? OP_MUL_RED :
                 (state_r == ST_BASE) ? OP_MUL_BASE :
                 (state_r == ST_ACC) ? OP_MUL_ACC : OP_MUL_SQR;
        cmd.mul_start = !started_r && !(state_r == ST_RED && sts.small_mod);
        started_nxt = !(started_r && sts.mul_done);
      end
      ST_CHECK: started_nxt = 1'b0;
      ST_DONE: if (!ov_r || out_ready) cmd.op = OP_FINISH;
      default: ;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (cmd.op == OP_FINISH) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ov_r      <= 1'b0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      started_r <= started_nxt;
    end
  end

  assign out_valid = ov_r;
endmodule

FILE: rtl/sequential_aggregate_rsa_sign_core.sv
// sequential aggregate rsa signing core
// in_valid/in_ready take one signer transaction (hash, exponent, modulus,
// last flag); out_valid/out_ready deliver one result transaction per signer
// with the running signature, the final mark and the sticky order flag.
// work per signer: the shared bit-serial modular multiplier (one multiplier
// bit per cycle) first reduces the running signature with one multiply,
// forms the base with a second, then runs square-and-multiply over the
// exponent bits; a modulus below two skips the multiplies and gives zero.
// one signer is processed at a time; the next transaction is taken at the
// earliest at the edge where the previous result is taken.
// a result held by a stalled receiver stays stable and stalls the core.
// reset (rst_n low, synchronous) sets the running signature to one, clears
// the previous modulus and order flag, and empties the output register.
// after a transaction marked last, the chain state restarts the same way.
module sequential_aggregate_rsa_sign_core #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sars_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sars_pkg::out_item_t out_data
);
  import sars_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sars_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  sars_datapath #(.MOD_BITS(MOD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_data), .cmd(cmd), .sts(sts),
    .res(out_data)
  );
endmodule
